// File: sv/ipv4fhb_pkg.sv
`timescale 1ns / 1ps

package ipv4fhb_pkg;

    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [15:0] MTU_FLOOR   = 16'd1044;
    localparam logic [15:0] VER_IHL_TOS = 16'h4500;
    localparam logic [15:0] PIECE_MASK  = 16'hFFF8;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_SUM,
        ST_EMIT
    } ctl_state_t;

    // header words folded into the checksum, one per step
    typedef enum logic [2:0] {
        SW_TOTAL_LEN,
        SW_IDENT,
        SW_FLAGS_OFF,
        SW_TTL_PROTO,
        SW_SRC_HI,
        SW_SRC_LO,
        SW_DST_HI,
        SW_DST_LO
    } sum_word_t;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  proto_number;
        logic [7:0]  time_to_live;
        logic [31:0] gateway_address;
        logic [12:0] base_frag_offset;
        logic        more_in;
        logic [15:0] ident_in;
        logic        last_frag_in;
        logic        direct_bcast;
    } req_t;

    typedef struct packed {
        logic [15:0] data_start;
        logic [15:0] total_len;
        logic [15:0] ident_out;
        logic        more_frag_flag;
        logic [12:0] frag_offset_out;
        logic [31:0] source_out;
        logic [15:0] header_checksum;
        logic [31:0] next_hop;
        logic        is_broadcast;
        logic        last_piece;
    } hdr_t;

    typedef struct packed {
        logic      capture;
        logic      setup;
        logic      sum_step;
        sum_word_t sum_word;
        logic      emit;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        logic ttl_zero;
        logic final_piece;
        logic out_free;
    } dp_sts_t;

endpackage

// File: sv/ipv4_fragment_header_builder_unit.sv
`timescale 1ns / 1ps

// ipv4 fragment header builder: takes one send request per accepted item and
// emits one 20-byte header descriptor item per fragment (none when ttl is
// zero), with the last descriptor of a request marked by tlast. a request
// is first accepted and checked; each fragment then has a setup step, the
// shared 16-bit ones' complement adder that folds the eight header words
// into the checksum one word per cycle, and a load of the output register
// that waits while the output side stalls; a request yields up to 64
// fragments. the output register lets the next request be accepted while
// the final descriptor still waits.
// configuration: mtu at byte address 0 (values below 1044 act as 1044),
// interface address at byte address 4; write only while the block is idle.

module ipv4_fragment_header_builder_unit
    import ipv4fhb_pkg::*;
#(
    parameter int MAX_FRAGMENTS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    // apb configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // payload_length[15:0], source_address[47:16], dest_address[79:48],
    // proto_number[87:80], time_to_live[95:88], gateway_address[127:96],
    // base_frag_offset[140:128], more_in[141], ident_in[157:142],
    // last_frag_in[158], zero pad[159]
    input  logic [159:0] s_axis_tdata,
    // direct_bcast[0]
    input  logic [0:0]   s_axis_tuser,
    // header descriptor stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // data_start[15:0], total_len[31:16], ident_out[47:32],
    // more_frag_flag[48], frag_offset_out[61:49], source_out[93:62],
    // header_checksum[109:94], next_hop[141:110], zero pad[143:142]
    output logic [143:0] m_axis_tdata,
    // is_broadcast[0]
    output logic [0:0]   m_axis_tuser,
    // last_piece
    output logic         m_axis_tlast
);

    logic [15:0] mtu_reg;
    logic [31:0] iface_reg;
    logic        cfg_wr;

    req_t        req;
    hdr_t        hdr;
    dp_cmd_t     cmd;
    dp_sts_t     sts;

    // configuration registers, word index taken from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg   <= 16'd1500;
            iface_reg <= 32'd0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                iface_reg <= pwdata;
            end
            else
            begin
                mtu_reg <= pwdata[15:0];
            end
        end
    end

    // reads of unaligned addresses return zero
    always_comb
    begin
        if (paddr[1:0] != 2'b00)
        begin
            prdata = 32'd0;
        end
        else if (paddr[2])
        begin
            prdata = iface_reg;
        end
        else
        begin
            prdata = {16'd0, mtu_reg};
        end
    end

    // unpack the request item
    assign req.payload_length   = s_axis_tdata[15:0];
    assign req.source_address   = s_axis_tdata[47:16];
    assign req.dest_address     = s_axis_tdata[79:48];
    assign req.proto_number     = s_axis_tdata[87:80];
    assign req.time_to_live     = s_axis_tdata[95:88];
    assign req.gateway_address  = s_axis_tdata[127:96];
    assign req.base_frag_offset = s_axis_tdata[140:128];
    assign req.more_in          = s_axis_tdata[141];
    assign req.ident_in         = s_axis_tdata[157:142];
    assign req.last_frag_in     = s_axis_tdata[158];
    assign req.direct_bcast     = s_axis_tuser[0];

    ipv4fhb_controller #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ipv4fhb_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .mtu               (mtu_reg),
        .interface_address (iface_reg),
        .req               (req),
        .cmd               (cmd),
        .sts               (sts),
        .out_ready         (m_axis_tready),
        .out_valid         (m_axis_tvalid),
        .out_hdr           (hdr)
    );

    // pack the descriptor item
    assign m_axis_tdata = {2'b00,
                           hdr.next_hop,
                           hdr.header_checksum,
                           hdr.source_out,
                           hdr.frag_offset_out,
                           hdr.more_frag_flag,
                           hdr.ident_out,
                           hdr.total_len,
                           hdr.data_start};
    assign m_axis_tuser = hdr.is_broadcast;
    assign m_axis_tlast = hdr.last_piece;

    // the input is closed again once a request has been accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened right after accepting a request");

    // the output register is only loaded when it is free
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("descriptor overwritten before it was taken");

    // while a non-final descriptor is taken, its request is still in work
    a_busy_mid_request: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |-> !s_axis_tready)
        else $error("new request accepted before the previous one finished");

    // descriptors never carry a total length below the header size
    a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (hdr.total_len >= HDR_BYTES))
        else $error("total length below header size");

endmodule

// File: sv/ipv4fhb_datapath.sv
`timescale 1ns / 1ps

module ipv4fhb_datapath
    import ipv4fhb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] mtu,
    input  logic [31:0] interface_address,
    input  req_t        req,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    input  logic        out_ready,
    output logic        out_valid,
    output hdr_t        out_hdr
);

    req_t        req_reg;
    logic [31:0] srcw_reg;
    logic [31:0] hop_reg;
    logic        frag_reg;
    logic [15:0] piece_reg;
    logic [16:0] x_reg;
    logic [15:0] tot_reg;
    logic [15:0] ident_reg;
    logic        mf_reg;
    logic [12:0] off_reg;
    logic        final_reg;
    logic [15:0] acc_reg;
    logic [15:0] ctr_reg;
    hdr_t        out_reg;
    logic        out_valid_reg;

    logic [15:0] eff_mtu;
    logic        frag_now;
    logic [16:0] x_plus;
    logic        fin;
    logic [15:0] y;
    logic        use_ctr;
    logic [15:0] sum_word;
    logic [16:0] sum_raw;

    assign eff_mtu  = (mtu < MTU_FLOOR) ? MTU_FLOOR : mtu;
    assign frag_now = ({1'b0, req.payload_length} + {1'b0, HDR_BYTES}) > {1'b0, eff_mtu};

    assign x_plus  = x_reg + {1'b0, piece_reg};
    assign fin     = x_plus >= {1'b0, req_reg.payload_length};
    assign y       = fin ? (req_reg.payload_length - x_reg[15:0]) : piece_reg;
    assign use_ctr = !frag_reg && (req_reg.base_frag_offset == 13'd0) && !req_reg.more_in;

    always_comb
    begin
        case (cmd.sum_word)
            SW_TOTAL_LEN: sum_word = tot_reg;
            SW_IDENT:     sum_word = ident_reg;
            SW_FLAGS_OFF: sum_word = {2'b00, mf_reg, off_reg};
            SW_TTL_PROTO: sum_word = {req_reg.time_to_live, req_reg.proto_number};
            SW_SRC_HI:    sum_word = srcw_reg[31:16];
            SW_SRC_LO:    sum_word = srcw_reg[15:0];
            SW_DST_HI:    sum_word = req_reg.dest_address[31:16];
            SW_DST_LO:    sum_word = req_reg.dest_address[15:0];
            default:      sum_word = 16'd0;
        endcase
    end

    assign sum_raw = {1'b0, acc_reg} + {1'b0, sum_word};

    // request capture and per-piece work registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req;
            srcw_reg  <= (req.source_address != 32'd0) ? req.source_address
                                                       : interface_address;
            hop_reg   <= req.direct_bcast ? 32'd0 : req.gateway_address;
            frag_reg  <= frag_now;
            piece_reg <= (eff_mtu - HDR_BYTES) & PIECE_MASK;
            x_reg     <= 17'd0;
        end
        if (cmd.setup)
        begin
            tot_reg   <= frag_reg ? (y + HDR_BYTES)
                                  : (req_reg.payload_length + HDR_BYTES);
            ident_reg <= use_ctr ? ctr_reg : req_reg.ident_in;
            mf_reg    <= frag_reg ? (fin ? req_reg.last_frag_in : 1'b1)
                                  : (req_reg.more_in | req_reg.last_frag_in);
            off_reg   <= req_reg.base_frag_offset + x_reg[15:3];
            final_reg <= frag_reg ? fin : 1'b1;
            acc_reg   <= VER_IHL_TOS;
        end
        if (cmd.sum_step)
        begin
            // ones' complement add with end-around carry
            acc_reg <= sum_raw[15:0] + {15'd0, sum_raw[16]};
        end
        if (cmd.emit)
        begin
            out_reg.data_start      <= x_reg[15:0];
            out_reg.total_len       <= tot_reg;
            out_reg.ident_out       <= ident_reg;
            out_reg.more_frag_flag  <= mf_reg;
            out_reg.frag_offset_out <= off_reg;
            out_reg.source_out      <= srcw_reg;
            out_reg.header_checksum <= ~acc_reg;
            out_reg.next_hop        <= hop_reg;
            out_reg.is_broadcast    <= req_reg.direct_bcast;
            out_reg.last_piece      <= cmd.last;
            x_reg                   <= x_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.setup && use_ctr)
            begin
                ctr_reg <= ctr_reg + 16'd1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.ttl_zero    = (req_reg.time_to_live == 8'd0);
    assign sts.final_piece = final_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_hdr   = out_reg;

endmodule

// File: sv/ipv4fhb_controller.sv
`timescale 1ns / 1ps

module ipv4fhb_controller
    import ipv4fhb_pkg::*;
#(
    parameter int MAX_FRAGMENTS = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam int CW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam logic [CW-1:0] LAST_N = CW'(MAX_FRAGMENTS - 1);

    ctl_state_t    state_reg;
    ctl_state_t    state_next;
    logic [2:0]    k_reg;
    logic [2:0]    k_next;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] n_next;
    logic          last_hit;

    assign last_hit = sts.final_piece || (n_reg == LAST_N);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_CHECK;
            ST_CHECK: state_next = sts.ttl_zero ? ST_IDLE : ST_SETUP;
            ST_SETUP: state_next = ST_SUM;
            ST_SUM:   if (k_reg == 3'd7) state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = last_hit ? ST_IDLE : ST_SETUP;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.setup    = 1'b0;
        cmd.sum_step = 1'b0;
        cmd.sum_word = sum_word_t'(k_reg);
        cmd.emit     = 1'b0;
        cmd.last     = last_hit;
        k_next       = k_reg;
        n_next       = n_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                n_next      = '0;
            end
            ST_CHECK: ;
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
                k_next    = 3'd0;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                k_next       = k_reg + 3'd1;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free)
                begin
                    n_next = n_reg + CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 3'd0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
        end
    end

endmodule
